[rtl/core/cdcema_pkg.sv]
package cdcema_pkg;

  // Field and register widths.
  localparam int VALUE_BITS  = 40;
  localparam int STATUS_BITS = 8;
  localparam int ALPHA_BITS  = 17;
  localparam int OFFSET_BITS = 24;
  localparam int GAIN_BITS   = 31;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // Binary point positions of the gain and smoothing weight products.
  localparam int GAIN_SHIFT  = 30;
  localparam int ALPHA_SHIFT = 16;

  // Smoothing weight of 1.0 in Q1.16.
  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = 17'd65536;
  localparam logic [ALPHA_BITS-1:0] ALPHA_MIN = 17'd1;

  // Register values after reset.
  localparam logic [ALPHA_BITS-1:0]  ALPHA_RST       = 17'd65536;
  localparam logic [OFFSET_BITS-1:0] CUR_OFFSET_RST  = -24'sd55026;
  localparam logic [GAIN_BITS-1:0]   CUR_GAIN_RST    = 31'd1074514489;
  localparam logic [OFFSET_BITS-1:0] VOLT_OFFSET_RST = 24'sd325662;
  localparam logic [GAIN_BITS-1:0]   VOLT_GAIN_RST   = 31'd1077274435;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ALPHA       = 3'd0,
    CFG_CUR_OFFSET  = 3'd1,
    CFG_CUR_GAIN    = 3'd2,
    CFG_VOLT_OFFSET = 3'd3,
    CFG_VOLT_GAIN   = 3'd4
  } cfg_reg_e;

  // One input request.
  typedef struct packed {
    logic                   path_select;
    logic [VALUE_BITS-1:0]  raw_sense_voltage;
    logic [VALUE_BITS-1:0]  raw_load_voltage;
    logic [STATUS_BITS-1:0] sense_adc_status;
    logic [STATUS_BITS-1:0] load_adc_status;
  } in_req_t;

  // One output request.
  typedef struct packed {
    logic [VALUE_BITS-1:0]  filtered_sense_voltage;
    logic [VALUE_BITS-1:0]  filtered_current;
    logic [VALUE_BITS-1:0]  filtered_raw_load;
    logic [VALUE_BITS-1:0]  filtered_load_voltage;
    logic [STATUS_BITS-1:0] sense_status_out;
    logic [STATUS_BITS-1:0] load_status_out;
  } out_req_t;

endpackage

[rtl/core/calibrated_dual_channel_ema_filter.sv]
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_req_i  (cdcema_pkg::in_req_t)
// out       output     out_valid_o / out_ready_i out_req_o (cdcema_pkg::out_req_t)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A request is taken only when idle, so the next one waits until this one commits; the
// internal path skips the gain products and a reload skips the smoothing product. The three
// lanes each have a bit-serial multiplier: 31 steps per gain product, 17 per smoothing one.
// A finished result waits in the output register; the next request is taken meanwhile
// and stalls only at its final commit until the output is free.
// Reset empties the filter and loads the register defaults; cfg is always ready.
module calibrated_dual_channel_ema_filter (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  cdcema_pkg::in_req_t                      in_req_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output cdcema_pkg::out_req_t                     out_req_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [cdcema_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [cdcema_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);

  localparam int W         = cdcema_pkg::VALUE_BITS;
  localparam int SB        = cdcema_pkg::STATUS_BITS;
  localparam int AB        = cdcema_pkg::ALPHA_BITS;
  localparam int OB        = cdcema_pkg::OFFSET_BITS;
  localparam int GB        = cdcema_pkg::GAIN_BITS;
  localparam int LANES     = 3;
  localparam int CNT_BITS  = $clog2(cdcema_pkg::GAIN_SHIFT + 1);

  localparam logic [CNT_BITS-1:0] CAL_LAST = CNT_BITS'(cdcema_pkg::GAIN_SHIFT);
  localparam logic [CNT_BITS-1:0] FIL_LAST = CNT_BITS'(cdcema_pkg::ALPHA_SHIFT);

  localparam logic [W-1:0]   VMAX    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   VMIN    = {1'b1, {(W-1){1'b0}}};
  localparam logic [W+1:0]   POS_LIM = {3'b000, {(W-1){1'b1}}};
  localparam logic [W+1:0]   NEG_LIM = {3'b001, {(W-1){1'b0}}};

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_ABS    = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_SAT    = 3'd4;
  localparam logic [2:0] ST_DIFF   = 3'd5;
  localparam logic [2:0] ST_UPD    = 3'd6;
  localparam logic [2:0] ST_COMMIT = 3'd7;

  // Lane 0 carries the sense voltage, lane 1 the raw load, lane 2 the
  // calibrated load. The current is identical to lane 0 at every step.
  localparam int LN_SENSE = 0;
  localparam int LN_RAW   = 1;
  localparam int LN_LOAD  = 2;

  // Control state.
  logic [2:0]          state_q, state_d;
  logic                phase_q, phase_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                loaded_q, loaded_d;
  logic                held_path_q, held_path_d;
  logic                out_valid_q, out_valid_d;

  // Configuration registers.
  logic [AB-1:0] alpha_q;
  logic [OB-1:0] cur_off_q;
  logic [GB-1:0] cur_gain_q;
  logic [OB-1:0] volt_off_q;
  logic [GB-1:0] volt_gain_q;

  // Captured request.
  logic          path_q, path_d;
  logic [W-1:0]  rs_q, rs_d;
  logic [W-1:0]  rl_q, rl_d;
  logic [SB-1:0] sts_s_q, sts_s_d;
  logic [SB-1:0] sts_l_q, sts_l_d;

  // Lane datapath.
  logic [W:0]    val_q  [LANES];
  logic [W:0]    val_d  [LANES];
  logic [W:0]    mag_q  [LANES];
  logic [W:0]    mag_d  [LANES];
  logic          neg_q  [LANES];
  logic          neg_d  [LANES];
  logic [W:0]    acc_q  [LANES];
  logic [W:0]    acc_d  [LANES];
  logic          low_q  [LANES];
  logic          low_d  [LANES];
  logic [GB-1:0] coef_q [LANES];
  logic [GB-1:0] coef_d [LANES];
  logic [W-1:0]  x_q    [LANES];
  logic [W-1:0]  x_d    [LANES];
  logic [W-1:0]  step_q [LANES];
  logic [W-1:0]  step_d [LANES];
  logic [W-1:0]  res_q  [LANES];
  logic [W-1:0]  res_d  [LANES];
  logic [W-1:0]  y_q    [LANES];
  logic [W-1:0]  y_d    [LANES];

  cdcema_pkg::out_req_t out_req_q, out_req_d;

  // Combinational helpers.
  logic [AB-1:0] alpha_eff;
  logic [W+1:0]  sum      [LANES];
  logic [W+1:0]  prod     [LANES];
  logic [W-1:0]  sat      [LANES];
  logic [W:0]    upd      [LANES];
  logic [W:0]    off_s_ext;
  logic [W:0]    off_l_ext;
  logic          reload;
  logic          commit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  // Smoothing weight limited to the range 1 .. 1.0.
  always_comb begin
    if (alpha_q == '0) begin
      alpha_eff = cdcema_pkg::ALPHA_MIN;
    end else if (alpha_q > cdcema_pkg::ALPHA_ONE) begin
      alpha_eff = cdcema_pkg::ALPHA_ONE;
    end else begin
      alpha_eff = alpha_q;
    end
  end

  assign off_s_ext = {{(W+1-OB){cur_off_q[OB-1]}}, cur_off_q};
  assign off_l_ext = {{(W+1-OB){volt_off_q[OB-1]}}, volt_off_q};
  assign reload    = !loaded_q || (path_q != held_path_q);
  assign commit    = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);

  // Per-lane multiplier step, saturation and smoothing update.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sum[l]  = {1'b0, acc_q[l]} + (coef_q[l][0] ? {1'b0, mag_q[l]} : '0);
      prod[l] = {acc_q[l], low_q[l]};
      if (!neg_q[l]) begin
        sat[l] = (prod[l] > POS_LIM) ? VMAX : prod[l][W-1:0];
      end else begin
        sat[l] = (prod[l] > NEG_LIM) ? VMIN : (~prod[l][W-1:0] + 1'b1);
      end
      upd[l] = {y_q[l][W-1], y_q[l]} + {step_q[l][W-1], step_q[l]};
    end
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    loaded_d    = loaded_q;
    held_path_d = held_path_q;
    out_valid_d = out_valid_q;
    path_d      = path_q;
    rs_d        = rs_q;
    rl_d        = rl_q;
    sts_s_d     = sts_s_q;
    sts_l_d     = sts_l_q;
    out_req_d   = out_req_q;
    for (int l = 0; l < LANES; l++) begin
      val_d[l]  = val_q[l];
      mag_d[l]  = mag_q[l];
      neg_d[l]  = neg_q[l];
      acc_d[l]  = acc_q[l];
      low_d[l]  = low_q[l];
      coef_d[l] = coef_q[l];
      x_d[l]    = x_q[l];
      step_d[l] = step_q[l];
      res_d[l]  = res_q[l];
      y_d[l]    = y_q[l];
    end

    // The output register drains independently of the sequencer.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          path_d  = in_req_i.path_select;
          rs_d    = in_req_i.raw_sense_voltage;
          rl_d    = in_req_i.raw_load_voltage;
          sts_s_d = in_req_i.sense_adc_status;
          sts_l_d = in_req_i.load_adc_status;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        x_d[LN_RAW] = rl_q;
        if (!path_q) begin
          // External path: remove the zero offsets, then scale by the gains.
          val_d[LN_SENSE]  = {rs_q[W-1], rs_q} - off_s_ext;
          val_d[LN_RAW]    = {rl_q[W-1], rl_q};
          val_d[LN_LOAD]   = {rl_q[W-1], rl_q} - off_l_ext;
          coef_d[LN_SENSE] = cur_gain_q;
          coef_d[LN_RAW]   = '0;
          coef_d[LN_LOAD]  = volt_gain_q;
          phase_d          = 1'b0;
          state_d          = ST_ABS;
        end else begin
          // Internal path: sense passes, load is negated with saturation.
          x_d[LN_SENSE] = rs_q;
          x_d[LN_LOAD]  = (rl_q == VMIN) ? VMAX : (~rl_q + 1'b1);
          state_d       = ST_DIFF;
        end
      end
      ST_ABS: begin
        for (int l = 0; l < LANES; l++) begin
          neg_d[l] = val_q[l][W];
          mag_d[l] = val_q[l][W] ? (~val_q[l] + 1'b1) : val_q[l];
          acc_d[l] = '0;
          low_d[l] = 1'b0;
        end
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        // One coefficient bit per cycle, least significant first.
        for (int l = 0; l < LANES; l++) begin
          acc_d[l]  = sum[l][W+1:1];
          low_d[l]  = sum[l][0];
          coef_d[l] = coef_q[l] >> 1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (phase_q ? FIL_LAST : CAL_LAST)) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        if (!phase_q) begin
          x_d[LN_SENSE] = sat[LN_SENSE];
          x_d[LN_LOAD]  = sat[LN_LOAD];
          state_d       = ST_DIFF;
        end else begin
          for (int l = 0; l < LANES; l++) begin
            step_d[l] = sat[l];
          end
          state_d = ST_UPD;
        end
      end
      ST_DIFF: begin
        if (reload) begin
          for (int l = 0; l < LANES; l++) begin
            res_d[l] = x_q[l];
          end
          state_d = ST_COMMIT;
        end else begin
          for (int l = 0; l < LANES; l++) begin
            val_d[l]  = {x_q[l][W-1], x_q[l]} - {y_q[l][W-1], y_q[l]};
            coef_d[l] = GB'(alpha_eff);
          end
          phase_d = 1'b1;
          state_d = ST_ABS;
        end
      end
      ST_UPD: begin
        // Add the step and clamp to the field range on overflow.
        for (int l = 0; l < LANES; l++) begin
          if (upd[l][W] != upd[l][W-1]) begin
            res_d[l] = upd[l][W] ? VMIN : VMAX;
          end else begin
            res_d[l] = upd[l][W-1:0];
          end
        end
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit) begin
          for (int l = 0; l < LANES; l++) begin
            y_d[l] = res_q[l];
          end
          loaded_d    = 1'b1;
          held_path_d = path_q;
          out_valid_d = 1'b1;
          out_req_d.filtered_sense_voltage = res_q[LN_SENSE];
          out_req_d.filtered_current       = res_q[LN_SENSE];
          out_req_d.filtered_raw_load      = res_q[LN_RAW];
          out_req_d.filtered_load_voltage  = res_q[LN_LOAD];
          out_req_d.sense_status_out       = sts_s_q;
          out_req_d.load_status_out        = sts_l_q;
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      cnt_q       <= '0;
      loaded_q    <= 1'b0;
      held_path_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      loaded_q    <= loaded_d;
      held_path_q <= held_path_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= cdcema_pkg::ALPHA_RST;
      cur_off_q   <= cdcema_pkg::CUR_OFFSET_RST;
      cur_gain_q  <= cdcema_pkg::CUR_GAIN_RST;
      volt_off_q  <= cdcema_pkg::VOLT_OFFSET_RST;
      volt_gain_q <= cdcema_pkg::VOLT_GAIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cdcema_pkg::CFG_ALPHA:       alpha_q     <= cfg_data_i[AB-1:0];
        cdcema_pkg::CFG_CUR_OFFSET:  cur_off_q   <= cfg_data_i[OB-1:0];
        cdcema_pkg::CFG_CUR_GAIN:    cur_gain_q  <= cfg_data_i[GB-1:0];
        cdcema_pkg::CFG_VOLT_OFFSET: volt_off_q  <= cfg_data_i[OB-1:0];
        cdcema_pkg::CFG_VOLT_GAIN:   volt_gain_q <= cfg_data_i[GB-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk_i) begin
    path_q    <= path_d;
    rs_q      <= rs_d;
    rl_q      <= rl_d;
    sts_s_q   <= sts_s_d;
    sts_l_q   <= sts_l_d;
    out_req_q <= out_req_d;
    for (int l = 0; l < LANES; l++) begin
      val_q[l]  <= val_d[l];
      mag_q[l]  <= mag_d[l];
      neg_q[l]  <= neg_d[l];
      acc_q[l]  <= acc_d[l];
      low_q[l]  <= low_d[l];
      coef_q[l] <= coef_d[l];
      x_q[l]    <= x_d[l];
      step_q[l] <= step_d[l];
      res_q[l]  <= res_d[l];
      y_q[l]    <= y_d[l];
    end
  end

endmodule
